// ----- src/two_wheel_equal_distance_regulator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the equal-distance regulator
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_WHEEL_EQUAL_DISTANCE_REGULATOR_TOP_DEFINES_SVH
`define TWO_WHEEL_EQUAL_DISTANCE_REGULATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define TWEDR_HOLDS(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("twedr: property violated");

// Next-cycle implication, sampled on clk, off during rst
`define TWEDR_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("twedr: property violated");

`endif

// ----- src/twedr_pkg.sv -----
// ----------------------------------------------------------------------------
// twedr_pkg
// Types and constants shared by the equal-distance regulator modules.
// ----------------------------------------------------------------------------
package twedr_pkg;

  // Drive floor applied to the corrected wheel
  localparam logic [7:0] FLOOR_DRIVE = 8'd0;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 44;
  localparam int MUL_B_W = 19;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Divider: 38-bit dividend, 16-bit divisor, two quotient bits per cycle
  localparam int DVD_W     = 38;
  localparam int DSR_W     = 16;
  localparam int DIV_STEP  = 2;
  localparam int DIV_ITER  = DVD_W / DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  typedef enum logic [2:0] {
    CFG_TARGET  = 3'd0,
    CFG_MODE    = 3'd1,
    CFG_BASE    = 3'd2,
    CFG_MIN     = 3'd3,
    CFG_RAMP    = 3'd4,
    CFG_GAIN    = 3'd5,
    CFG_SCALE_L = 3'd6,
    CFG_SCALE_R = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_FORWARD  = 3'd1,
    MODE_REVERSE  = 3'd2,
    MODE_PIVOT_CW = 3'd3,
    MODE_PIVOT_CCW = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DA,
    S_DB,
    S_NUM,
    S_SUM,
    S_DIV,
    S_CORR,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [15:0] target_distance;
    logic [2:0]  movement_mode;
    logic [7:0]  base_drive;
    logic [7:0]  min_drive;
    logic [15:0] ramp_distance;
    logic [11:0] balance_gain;
    logic [17:0] scale_left;
    logic [17:0] scale_right;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic       left_in_one;
    logic       left_in_two;
    logic [7:0] left_level;
    logic       right_in_one;
    logic       right_in_two;
    logic [7:0] right_level;
    logic       move_done;
  } res_t;

endpackage

// ----- src/twedr_cfg.sv -----
// ----------------------------------------------------------------------------
// twedr_cfg
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
module twedr_cfg
  import twedr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_distance <= 16'd0;
      cfg.movement_mode   <= MODE_NONE;
      cfg.base_drive      <= 8'd100;
      cfg.min_drive       <= 8'd0;
      cfg.ramp_distance   <= 16'd1;
      cfg.balance_gain    <= 12'd0;
      cfg.scale_left      <= 18'd0;
      cfg.scale_right     <= 18'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET:  cfg.target_distance <= cfg_data[15:0];
        CFG_MODE:    cfg.movement_mode   <= cfg_data[2:0];
        CFG_BASE:    cfg.base_drive      <= cfg_data[7:0];
        CFG_MIN:     cfg.min_drive       <= cfg_data[7:0];
        CFG_RAMP:    cfg.ramp_distance   <= cfg_data[15:0];
        CFG_GAIN:    cfg.balance_gain    <= cfg_data[11:0];
        CFG_SCALE_L: cfg.scale_left      <= cfg_data;
        CFG_SCALE_R: cfg.scale_right     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/twedr_mul.sv -----
// ----------------------------------------------------------------------------
// twedr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module twedr_mul
  import twedr_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] mul_a,
  input  logic signed [MUL_B_W-1:0] mul_b,
  output logic signed [MUL_P_W-1:0] mul_p
);

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

endmodule

// ----- src/twedr_div.sv -----
// ----------------------------------------------------------------------------
// twedr_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module twedr_div
  import twedr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DSR_W-1:0]     rem;
  logic [DSR_W-1:0]     rem_next;
  logic [DVD_W-1:0]     quo;
  logic [DVD_W-1:0]     quo_next;
  logic [DSR_W-1:0]     dsr;

  always_comb begin
    logic [DSR_W:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial    = {rem_next, quo_next[DVD_W-1]};
      quo_next = {quo_next[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem_next    = DSR_W'(trial - {1'b0, dsr});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[DSR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- src/twedr_seq.sv -----
// ----------------------------------------------------------------------------
// twedr_seq
// Per-sample sequencer and datapath: end test, distances, ramp, balance
// correction and bridge decode, using the shared multiplier and divider.
// ----------------------------------------------------------------------------
module twedr_seq
  import twedr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [23:0]        ticks_left,
  input  logic signed [23:0]        ticks_right,
  input  logic                      new_move,
  output logic signed [MUL_A_W-1:0] mul_a,
  output logic signed [MUL_B_W-1:0] mul_b,
  input  logic signed [MUL_P_W-1:0] mul_p,
  output div_req_t                  div_req,
  input  div_rsp_t                  div_rsp,
  output logic                      out_valid,
  input  logic                      out_stall,
  output res_t                      out_res
);

  state_t state;
  state_t state_next;

  // sample and model state
  logic signed [23:0] tick_l;
  logic signed [23:0] tick_r;
  logic signed [41:0] last_dist_l;
  logic signed [41:0] last_dist_r;
  logic signed [42:0] wdiff;
  logic               finished;

  // working registers
  logic signed [41:0] da;
  logic signed [41:0] db;
  logic signed [53:0] num;
  logic signed [38:0] base_mot;
  logic signed [63:0] corr_q;
  res_t               res;

  // combinational datapath
  logic        accept;
  logic        out_load;
  logic [15:0] ramp_eff;
  logic [41:0] da_abs;
  logic [41:0] db_abs;
  logic [41:0] last_abs_l;
  logic [41:0] last_abs_r;
  logic [41:0] prev_max;
  logic        at_end;
  logic signed [16:0] thr;
  logic        down_ramp;
  logic        up_ramp;
  logic signed [43:0] ramp_x;
  logic signed [8:0]  drive_span;
  logic signed [53:0] num_sum;
  logic [53:0] num_abs;
  logic [38:0] quo39;
  logic signed [63:0] prod64;
  logic signed [63:0] bm24;
  logic        wdiff_pos;
  logic [38:0] bm_abs;
  logic        bm_neg;
  logic        bm_zero;
  logic [7:0]  bm_sat;
  logic        fl_neg;
  logic        fl_zero;
  logic [7:0]  fl_sat;
  logic        s1_pos;
  logic        s1_neg;
  logic        s2_pos;
  logic        s2_neg;
  res_t        drive_res;
  res_t        brake_res;

  localparam logic signed [63:0] FLOOR_Q = {32'd0, FLOOR_DRIVE, 24'd0};

  function automatic logic [9:0] bridge(input logic s_pos, input logic s_neg,
                                        input logic m_neg, input logic m_zero,
                                        input logic [7:0] m_sat);
    logic p_pos;
    logic [7:0] lvl;
    p_pos = (s_pos && !m_neg && !m_zero) || (s_neg && m_neg);
    lvl   = (s_pos || s_neg) ? m_sat : 8'd0;
    return {p_pos, !p_pos, lvl};
  endfunction

  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    ramp_eff   = (cfg.ramp_distance == 16'd0) ? 16'd1 : cfg.ramp_distance;
    da_abs     = 42'(da[41] ? -da : da);
    db_abs     = 42'(db[41] ? -db : db);
    last_abs_l = 42'(last_dist_l[41] ? -last_dist_l : last_dist_l);
    last_abs_r = 42'(last_dist_r[41] ? -last_dist_r : last_dist_r);
    prev_max   = (last_abs_r > last_abs_l) ? last_abs_r : last_abs_l;
    at_end     = finished || (prev_max >= {10'd0, cfg.target_distance, 16'd0});

    thr        = $signed({1'b0, cfg.target_distance}) - $signed({1'b0, ramp_eff});
    down_ramp  = $signed({1'b0, da_abs}) > $signed({{10{thr[16]}}, thr, 16'd0});
    up_ramp    = da_abs < {10'd0, ramp_eff, 16'd0};
    ramp_x     = down_ramp
               ? $signed({12'd0, cfg.target_distance, 16'd0}) - $signed({2'd0, da_abs})
               : $signed({2'd0, da_abs});
    drive_span = $signed({1'b0, cfg.base_drive}) - $signed({1'b0, cfg.min_drive});

    num_sum    = num + $signed({14'd0, mul_p[23:0], 16'd0});
    num_abs    = 54'(num_sum[53] ? -num_sum : num_sum);
    quo39      = {1'b0, div_rsp.quotient};

    prod64     = {mul_p[MUL_P_W-1], mul_p};
    bm24       = {base_mot[38], base_mot, 24'd0};
    wdiff_pos  = !wdiff[42] && (wdiff != '0);

    // uncorrected wheel magnitude
    bm_neg     = base_mot[38];
    bm_abs     = 39'(bm_neg ? -base_mot : base_mot);
    bm_zero    = (base_mot == '0);
    bm_sat     = (bm_abs[38:8] != '0) ? 8'd255 : bm_abs[7:0];

    // corrected wheel magnitude, held at the floor
    fl_neg     = 1'b0;
    if (corr_q <= FLOOR_Q) begin
      fl_zero = (FLOOR_DRIVE == 8'd0);
      fl_sat  = FLOOR_DRIVE;
    end else begin
      fl_zero = (corr_q[62:24] == '0);
      fl_sat  = (corr_q[62:32] != '0) ? 8'd255 : corr_q[31:24];
    end

    case (cfg.movement_mode)
      MODE_FORWARD:   {s1_pos, s1_neg, s2_pos, s2_neg} = 4'b1010;
      MODE_REVERSE:   {s1_pos, s1_neg, s2_pos, s2_neg} = 4'b0101;
      MODE_PIVOT_CW:  {s1_pos, s1_neg, s2_pos, s2_neg} = 4'b0110;
      MODE_PIVOT_CCW: {s1_pos, s1_neg, s2_pos, s2_neg} = 4'b1001;
      default:        {s1_pos, s1_neg, s2_pos, s2_neg} = 4'b0000;
    endcase

    if (wdiff_pos) begin
      {drive_res.left_in_one, drive_res.left_in_two, drive_res.left_level} =
        bridge(s1_pos, s1_neg, fl_neg, fl_zero, fl_sat);
      {drive_res.right_in_one, drive_res.right_in_two, drive_res.right_level} =
        bridge(s2_pos, s2_neg, bm_neg, bm_zero, bm_sat);
    end else begin
      {drive_res.left_in_one, drive_res.left_in_two, drive_res.left_level} =
        bridge(s1_pos, s1_neg, bm_neg, bm_zero, bm_sat);
      {drive_res.right_in_one, drive_res.right_in_two, drive_res.right_level} =
        bridge(s2_pos, s2_neg, fl_neg, fl_zero, fl_sat);
    end
    drive_res.move_done = 1'b0;

    brake_res = '{left_in_one: 1'b1, left_in_two: 1'b1, left_level: 8'd0,
                  right_in_one: 1'b1, right_in_two: 1'b1, right_level: 8'd0,
                  move_done: 1'b1};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CHECK;
      S_CHECK: state_next = at_end ? S_OUT : S_DA;
      S_DA:    state_next = S_DB;
      S_DB:    state_next = (down_ramp || up_ramp) ? S_NUM : S_CORR;
      S_NUM:   state_next = S_SUM;
      S_SUM:   state_next = S_DIV;
      S_DIV:   if (div_rsp.done) state_next = S_CORR;
      S_CORR:  state_next = S_FIN;
      S_FIN:   state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs and multiplier operand select
  always_comb begin
    in_stall         = (state != S_IDLE);
    div_req.start    = (state == S_SUM);
    div_req.dividend = num_abs[53:16];
    div_req.divisor  = ramp_eff;
    case (state)
      S_CHECK: begin
        mul_a = MUL_A_W'(tick_l);
        mul_b = $signed({1'b0, cfg.scale_left});
      end
      S_DA: begin
        mul_a = MUL_A_W'(tick_r);
        mul_b = $signed({1'b0, cfg.scale_right});
      end
      S_DB: begin
        if (down_ramp || up_ramp) begin
          mul_a = ramp_x;
          mul_b = MUL_B_W'(drive_span);
        end else begin
          mul_a = MUL_A_W'(wdiff);
          mul_b = $signed({7'd0, cfg.balance_gain});
        end
      end
      S_NUM: begin
        mul_a = $signed({36'd0, cfg.min_drive});
        mul_b = $signed({3'd0, ramp_eff});
      end
      default: begin
        mul_a = MUL_A_W'(wdiff);
        mul_b = $signed({7'd0, cfg.balance_gain});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      finished    <= 1'b0;
      last_dist_l <= '0;
      last_dist_r <= '0;
      wdiff       <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept && new_move) begin
        finished    <= 1'b0;
        last_dist_l <= '0;
        last_dist_r <= '0;
        wdiff       <= '0;
      end
      if (state == S_CHECK && at_end) begin
        finished <= 1'b1;
      end
      if (state == S_FIN) begin
        wdiff       <= $signed({1'b0, da_abs}) - $signed({1'b0, db_abs});
        last_dist_l <= da;
        last_dist_r <= db;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick_l <= ticks_left;
      tick_r <= ticks_right;
    end
    case (state)
      S_CHECK: if (at_end) res <= brake_res;
      S_DA:    da <= mul_p[41:0];
      S_DB: begin
        db <= mul_p[41:0];
        if (!down_ramp && !up_ramp) base_mot <= {31'd0, cfg.base_drive};
      end
      S_NUM:   num <= mul_p[53:0];
      // hold the full numerator; its sign sets the sign of the quotient
      S_SUM:   num <= num_sum;
      S_DIV: begin
        if (div_rsp.done) base_mot <= num[53] ? -quo39 : quo39;
      end
      S_CORR:  corr_q <= wdiff_pos ? bm24 - prod64 : bm24 + prod64;
      S_FIN:   res <= drive_res;
      default: ;
    endcase
    if (out_load) out_res <= res;
  end

endmodule

// ----- src/two_wheel_equal_distance_regulator_top.sv -----
// ----------------------------------------------------------------------------
// Two-wheel equal-distance regulator
// Turns encoder samples into H-bridge pins and PWM levels for both wheels.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration words arrive on cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write only while no sample is in work.
//   Each input word (ticks_left, ticks_right, new_move) is taken when in_valid
//   is high and in_stall low; new_move starts a fresh move. Each sample gives
//   exactly one output word, taken when out_valid is high and out_stall low.
//   From acceptance the sequencer steps S_CHECK, S_DA, S_DB, S_CORR, S_FIN,
//   S_OUT at cruise and S_CHECK, S_OUT when the move has ended (brake word);
//   a ramp adds S_NUM, S_SUM and S_DIV, where the divider runs 19 iterations.
//   One sample is in work at a time; in_stall is high until the word is
//   loaded into the output register, so the next sample may enter while the
//   previous output word still waits. A stalled receiver holds the output
//   word and, once the next result is ready, holds the sequencer too.
//   Reset clears the move state, the configuration to its defaults and the
//   output valid.
// ----------------------------------------------------------------------------
module two_wheel_equal_distance_regulator_top
  import twedr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] ticks_left,
  input  logic signed [23:0] ticks_right,
  input  logic               new_move,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               left_in_one,
  output logic               left_in_two,
  output logic [7:0]         left_level,
  output logic               right_in_one,
  output logic               right_in_two,
  output logic [7:0]         right_level,
  output logic               move_done
);

  cfg_t                      cfg;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  res_t                      out_res;

  twedr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  twedr_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  twedr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  twedr_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .ticks_left  (ticks_left),
    .ticks_right (ticks_right),
    .new_move    (new_move),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .mul_p       (mul_p),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res)
  );

  assign left_in_one  = out_res.left_in_one;
  assign left_in_two  = out_res.left_in_two;
  assign left_level   = out_res.left_level;
  assign right_in_one = out_res.right_in_one;
  assign right_in_two = out_res.right_in_two;
  assign right_level  = out_res.right_level;
  assign move_done    = out_res.move_done;

endmodule

// ----- src/twedr_chk.sv -----
// ----------------------------------------------------------------------------
// twedr_chk
// Port-level checker for the equal-distance regulator, bound to the top.
// ----------------------------------------------------------------------------
`include "two_wheel_equal_distance_regulator_top_defines.svh"

module twedr_chk (
  input logic               clk,
  input logic               rst,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [17:0]        cfg_data,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [23:0] ticks_left,
  input logic signed [23:0] ticks_right,
  input logic               new_move,
  input logic               out_valid,
  input logic               out_stall,
  input logic               left_in_one,
  input logic               left_in_two,
  input logic [7:0]         left_level,
  input logic               right_in_one,
  input logic               right_in_two,
  input logic [7:0]         right_level,
  input logic               move_done
);

  // a stalled word stays offered and unchanged
  `TWEDR_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `TWEDR_NEXT(a_out_stable, out_valid && out_stall, $stable(left_level) && $stable(right_level) && $stable(move_done))

  // a taken sample keeps the block busy for at least the next cycle
  `TWEDR_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // done words brake both bridges at level zero
  `TWEDR_HOLDS(a_done_brakes, out_valid && move_done, left_in_one && left_in_two && right_in_one && right_in_two && left_level == 8'd0 && right_level == 8'd0)

  // while driving, each bridge has exactly one pin high
  `TWEDR_HOLDS(a_drive_pins, out_valid && !move_done, (left_in_one != left_in_two) && (right_in_one != right_in_two))

endmodule

bind two_wheel_equal_distance_regulator_top twedr_chk u_twedr_chk (.*);
